>>> rtl/btmx_pkg.sv
// Shared constants, types and helpers for the binary trie max-XOR unit.
// Depends on nothing; imported by the top level and the testbench.
package btmx_pkg;

    localparam int KEY_BITS    = 21;
    localparam int POOL_NODES  = 4096;

    localparam int NODE_W      = $clog2(POOL_NODES);
    localparam int CNT_W       = $clog2(POOL_NODES + 1);
    localparam int LVL_W       = $clog2(KEY_BITS);
    localparam int PRESET_ROWS = KEY_BITS + 1;
    localparam int PRESET_W    = $clog2(PRESET_ROWS);

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [LVL_W-1:0]    lvl_t;

    // one memory row per node: both child links
    typedef struct packed {
        node_t link1;
        node_t link0;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    localparam logic [CNT_W:0] POOL_LIMIT = (CNT_W + 1)'(POOL_NODES);
    localparam cnt_t           USED_RESET = CNT_W'(PRESET_ROWS);
    localparam lvl_t           TOP_LVL    = LVL_W'(KEY_BITS - 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_FILL = 3'b100
    } state_t;

    // Row contents right after reset: the zero-key path, node n -> n+1 via child 0.
    function automatic row_t preset_row(input node_t node);
        row_t r;
        r.link1 = '0;
        if (node < NODE_W'(KEY_BITS))
            r.link0 = node + 1'b1;
        else
            r.link0 = '0;
        return r;
    endfunction

endpackage

>>> rtl/btmx_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module btmx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/binary_trie_max_xor_unit.sv
// Top level of the binary trie max-XOR unit: request sequencer over a node RAM.
// Depends on btmx_pkg and btmx_ram.
//
// Usage:
//   Request channel: drive operation and key, raise start. The item is taken
//   at a rising edge where start is high and busy is low. operation 0 inserts
//   key, 1 asks for the largest XOR of key with any stored key.
//   Result channel: done pulses for one cycle with best_xor and status. Every
//   request gives exactly one result. The receiver cannot stall it, so the
//   result must be captured in the cycle done is high.
// Timing:
//   The walk reads one node row per cycle from the node RAM (one read port,
//   registered read), one trie level per cycle over KEY_BITS levels.
//   An insert that allocates nodes writes one new row per cycle after the
//   missing link is found, so its walk and fill last equally long whatever
//   level the link is missing at. A duplicate insert or a dropped one ends
//   as soon as its walk ends. done shows in the cycle in which busy falls,
//   so the next start can be taken together with it.
// Reset:
//   The trie holds key 0 right after reset, with no startup sweep: the rows
//   of the root and the zero path carry touched flags and read as their
//   preset contents until first written. Rows above the fill count are
//   always written in full when allocated, before anything reads them.
module binary_trie_max_xor_unit
    import btmx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                operation,
    input  logic [KEY_BITS-1:0] key,
    output logic                done,
    output logic [KEY_BITS-1:0] best_xor,
    output logic                status
);

    state_t state_reg, state_next;
    node_t  node_reg, node_next;     // node whose row is on rd_data in WALK
    lvl_t   lvl_reg, lvl_next;       // key bit being consumed
    key_t   key_reg, key_next;
    logic   op_reg, op_next;
    key_t   ans_reg, ans_next;       // query answer built so far
    node_t  alloc_reg, alloc_next;   // next row to write in FILL
    cnt_t   used_reg, used_next;     // nodes allocated
    logic [PRESET_ROWS-1:0] touched_reg, touched_next;

    logic   done_reg, done_next;
    key_t   xor_reg, xor_next;
    logic   status_reg, status_next;

    // node RAM port signals
    logic   rd_en;
    node_t  rd_addr;
    row_t   rd_row;
    logic   wr_en;
    node_t  wr_addr;
    row_t   wr_row;

    btmx_ram #(
        .WIDTH (ROW_W),
        .DEPTH (POOL_NODES)
    ) u_links (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    // Preset rows read as their reset contents until first written.
    logic                in_preset;
    logic [PRESET_W-1:0] pidx;
    logic                untouched;
    row_t                row_eff;

    assign in_preset = (node_reg < NODE_W'(PRESET_ROWS));
    assign pidx      = node_reg[PRESET_W-1:0];
    assign untouched = in_preset && !touched_reg[pidx];
    assign row_eff   = untouched ? preset_row(node_reg) : rd_row;

    // Per-level decode
    logic   cur_bit;
    node_t  same_link;
    node_t  opp_link;
    cnt_t   need;
    logic   fits;
    logic   fill_bit;
    node_t  query_nxt;

    assign cur_bit   = key_reg[lvl_reg];
    assign same_link = cur_bit ? row_eff.link1 : row_eff.link0;
    assign opp_link  = cur_bit ? row_eff.link0 : row_eff.link1;
    // a missing link at this level means this level and all below need a node
    assign need      = CNT_W'(lvl_reg) + 1'b1;
    assign fits      = ({1'b0, used_reg} + {1'b0, need}) <= POOL_LIMIT;
    assign fill_bit  = key_reg[lvl_t'(lvl_reg - 1'b1)];
    assign query_nxt = (opp_link != '0) ? opp_link : same_link;

    always_comb
    begin
        state_next   = state_reg;
        node_next    = node_reg;
        lvl_next     = lvl_reg;
        key_next     = key_reg;
        op_next      = op_reg;
        ans_next     = ans_reg;
        alloc_next   = alloc_reg;
        used_next    = used_reg;
        touched_next = touched_reg;
        done_next    = 1'b0;
        xor_next     = xor_reg;
        status_next  = status_reg;

        rd_en   = 1'b0;
        rd_addr = node_reg;
        wr_en   = 1'b0;
        wr_addr = node_reg;
        wr_row  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next   = key;
                    op_next    = operation;
                    node_next  = '0;
                    lvl_next   = TOP_LVL;
                    ans_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (same_link != '0)
                    begin
                        if (lvl_reg == '0)
                        begin
                            // key already stored
                            done_next   = 1'b1;
                            xor_next    = '0;
                            status_next = STATUS_DONE;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            node_next = same_link;
                            rd_en     = 1'b1;
                            rd_addr   = same_link;
                            lvl_next  = lvl_reg - 1'b1;
                        end
                    end
                    else if (!fits)
                    begin
                        // pool full: drop the whole insert
                        done_next   = 1'b1;
                        xor_next    = '0;
                        status_next = STATUS_FULL;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        // hook the first new node into the parent row
                        wr_en   = 1'b1;
                        wr_addr = node_reg;
                        wr_row  = row_eff;
                        if (cur_bit)
                            wr_row.link1 = used_reg[NODE_W-1:0];
                        else
                            wr_row.link0 = used_reg[NODE_W-1:0];
                        if (in_preset)
                            touched_next[pidx] = 1'b1;
                        alloc_next = used_reg[NODE_W-1:0];
                        used_next  = used_reg + need;
                        state_next = ST_FILL;
                    end
                end
                else
                begin
                    if (opp_link != '0)
                        ans_next[lvl_reg] = 1'b1;
                    if (query_nxt == '0 || lvl_reg == '0)
                    begin
                        done_next   = 1'b1;
                        xor_next    = ans_next;
                        status_next = STATUS_DONE;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        node_next = query_nxt;
                        rd_en     = 1'b1;
                        rd_addr   = query_nxt;
                        lvl_next  = lvl_reg - 1'b1;
                    end
                end
            end

            ST_FILL:
            begin
                // fresh chain: each new row links only to the next new node
                wr_en   = 1'b1;
                wr_addr = alloc_reg;
                if (lvl_reg == '0)
                begin
                    done_next   = 1'b1;
                    xor_next    = '0;
                    status_next = STATUS_DONE;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    if (fill_bit)
                        wr_row.link1 = alloc_reg + 1'b1;
                    else
                        wr_row.link0 = alloc_reg + 1'b1;
                    alloc_next = alloc_reg + 1'b1;
                    lvl_next   = lvl_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            used_reg    <= USED_RESET;
            touched_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            touched_reg <= touched_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        lvl_reg    <= lvl_next;
        key_reg    <= key_next;
        op_reg     <= op_next;
        ans_reg    <= ans_next;
        alloc_reg  <= alloc_next;
        xor_reg    <= xor_next;
        status_reg <= status_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign best_xor = xor_reg;
    assign status   = status_reg;

`ifndef SYNTHESIS
    // an accepted request always shows busy in the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

    // result comes out exactly as the sequencer returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside end of request");

    // a dropped insert reports no XOR value
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FULL) |-> (best_xor == '0 && op_reg == OP_INSERT))
        else $error("pool-full status on a query or with nonzero answer");

    // allocation never runs past the pool
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, used_reg} <= POOL_LIMIT) && (used_reg >= USED_RESET))
        else $error("node count out of range");

    // the node RAM is only written while an insert is in progress
    a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (busy && op_reg == OP_INSERT))
        else $error("node RAM write outside an insert");
`endif

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for binary_trie_max_xor_unit: inserts and max-XOR queries
// against a built-in trie model. Depends on btmx_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;
    import btmx_pkg::*;

    // The slowest correct run of about 1950 items stays well below this limit.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_TARGET  = 1950;
    // Drain wait after the last result: one full walk plus margin.
    localparam int DRAIN_CYCLES = KEY_BITS + 10;

    // One expected result, tagged with the item that caused it.
    typedef struct {
        logic op;
        key_t key;
        key_t best_xor;
        logic status;
    } trie_result_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic start     = 1'b0;
    logic operation = OP_INSERT;
    key_t key       = '0;
    logic busy;
    logic done;
    key_t best_xor;
    logic status;

    binary_trie_max_xor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .key       (key),
        .done      (done),
        .best_xor  (best_xor),
        .status    (status)
    );

    always #10 clk = ~clk;

    // Trie mirror: child links per node (0 = null) and the allocation count.
    node_t link_zero [POOL_NODES];
    node_t link_one  [POOL_NODES];
    int    nodes_in_use;

    trie_result_t expected_results [$];
    trie_result_t oldest_result;
    key_t         stored_keys [$];   // keys whose insert succeeded, for near-miss stimulus

    int  error_count   = 0;
    int  items_sent    = 0;
    int  insert_count  = 0;
    int  query_count   = 0;
    int  dropped_count = 0;
    int  results_seen  = 0;
    bit  gaps_on       = 1'b1;      // off gives back-to-back items

    //------------------------------------------------------------------
    // Trie mirror
    //------------------------------------------------------------------

    // Reset contents: root plus the path of key 0, node n -> n+1 via child 0.
    function automatic void trie_clear();
        int n;
        for (n = 0; n < POOL_NODES; n++)
        begin
            link_zero[n] = '0;
            link_one[n]  = '0;
        end
        for (n = 0; n < KEY_BITS; n++)
            link_zero[n] = node_t'(n + 1);
        nodes_in_use = KEY_BITS + 1;
    endfunction

    // Nodes an insert of k would allocate: once a link is missing, so is
    // everything below it.
    function automatic int trie_nodes_missing(key_t k);
        node_t node;
        node_t nxt;
        int    lvl;
        node = '0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--)
        begin
            nxt = k[lvl] ? link_one[node] : link_zero[node];
            if (nxt == '0)
                return lvl + 1;
            node = nxt;
        end
        return 0;
    endfunction

    // Insert is all-or-nothing: a pool overflow drops it before any link changes.
    function automatic logic trie_insert(key_t k);
        node_t node;
        node_t nxt;
        int    lvl;
        if (nodes_in_use + trie_nodes_missing(k) > POOL_NODES)
            return STATUS_FULL;
        node = '0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--)
        begin
            nxt = k[lvl] ? link_one[node] : link_zero[node];
            if (nxt == '0)
            begin
                nxt = node_t'(nodes_in_use);
                nodes_in_use++;
                link_zero[nxt] = '0;
                link_one[nxt]  = '0;
                if (k[lvl])
                    link_one[node] = nxt;
                else
                    link_zero[node] = nxt;
            end
            node = nxt;
        end
        return STATUS_DONE;
    endfunction

    // Greedy walk: take the opposite-bit child when present and set that answer bit.
    // A node with no child at all ends the walk with the bits found so far.
    function automatic key_t trie_max_xor(key_t k);
        node_t node;
        node_t opp;
        node_t same;
        key_t  answer;
        int    lvl;
        node   = '0;
        answer = '0;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--)
        begin
            opp = k[lvl] ? link_zero[node] : link_one[node];
            if (opp != '0)
            begin
                answer[lvl] = 1'b1;
                node = opp;
            end
            else
            begin
                same = k[lvl] ? link_one[node] : link_zero[node];
                if (same == '0)
                    break;
                node = same;
            end
        end
        return answer;
    endfunction

    function automatic key_t pick_stored_key();
        if (stored_keys.size() == 0)
            return key_t'($urandom());
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    //------------------------------------------------------------------
    // Request side
    //------------------------------------------------------------------

    // Called at a rising edge. start stays high from one item to the next when
    // no gap is drawn, so it never gets two assignments in one step. The item is
    // predicted at the edge where start is high and busy is low.
    task automatic send_item(input logic op, input key_t k);
        int           gap;
        trie_result_t predicted;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation <= op;
        key       <= k;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        predicted.op  = op;
        predicted.key = k;
        if (op == OP_INSERT)
        begin
            predicted.best_xor = '0;
            predicted.status   = trie_insert(k);
            insert_count++;
            if (predicted.status == STATUS_FULL)
                dropped_count++;
            else if (stored_keys.size() < POOL_NODES)
                stored_keys.push_back(k);
        end
        else
        begin
            predicted.best_xor = trie_max_xor(k);
            predicted.status   = STATUS_DONE;
            query_count++;
        end
        expected_results.push_back(predicted);
        items_sent++;
    endtask

    //------------------------------------------------------------------
    // Result side: done is a one-cycle strobe, sampled at the edge ending it
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with no item pending: best_xor %h status %b", best_xor, status);
                error_count++;
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (best_xor !== oldest_result.best_xor)
                begin
                    $error("best_xor mismatch (op %b key %h): expected %h, actual %h",
                           oldest_result.op, oldest_result.key,
                           oldest_result.best_xor, best_xor);
                    error_count++;
                end
                if (status !== oldest_result.status)
                begin
                    $error("status mismatch (op %b key %h): expected %b, actual %b",
                           oldest_result.op, oldest_result.key,
                           oldest_result.status, status);
                    error_count++;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Extremes on the reset trie, duplicates, single-node inserts and
    // alternating bit patterns; run back to back.
    task automatic test_directed();
        gaps_on = 1'b0;
        send_item(OP_QUERY,  '0);               // only key 0 stored
        send_item(OP_QUERY,  '1);
        send_item(OP_INSERT, '0);               // duplicate of the reset key
        send_item(OP_INSERT, '1);
        send_item(OP_QUERY,  '0);
        send_item(OP_QUERY,  '1);
        send_item(OP_INSERT, key_t'(21'h000001)); // one new leaf off the zero path
        send_item(OP_QUERY,  key_t'(21'h000001));
        send_item(OP_INSERT, key_t'(21'h100000));
        send_item(OP_QUERY,  key_t'(21'h0FFFFF));
        send_item(OP_INSERT, key_t'(21'h155555));
        send_item(OP_INSERT, key_t'(21'h0AAAAA));
        send_item(OP_QUERY,  key_t'(21'h155555));
        send_item(OP_QUERY,  key_t'(21'h0AAAAA));
        send_item(OP_INSERT, key_t'(21'h1FFFFE));
        send_item(OP_QUERY,  key_t'(21'h000001));
        send_item(OP_INSERT, key_t'(21'h155555)); // duplicate
        send_item(OP_QUERY,  key_t'(21'h1FFFFF));
        gaps_on = 1'b1;
    endtask

    // Fill the node pool. Once fewer than a path's worth of nodes are left,
    // half the inserts are stored keys with one bit flipped low enough to fit,
    // which drives the count to exactly full; random keys mostly get dropped.
    task automatic test_fill_pool();
        int   rounds;
        int   free_nodes;
        int   flip;
        int   drops_at_entry;
        key_t k;
        rounds         = 0;
        drops_at_entry = dropped_count;
        while (rounds < 1500 && (nodes_in_use < POOL_NODES || dropped_count - drops_at_entry < 20))
        begin
            free_nodes = POOL_NODES - nodes_in_use;
            if ($urandom_range(0, 3) == 0)
                send_item(OP_QUERY, key_t'($urandom()));
            else if (free_nodes < KEY_BITS && $urandom_range(0, 1) == 1)
            begin
                flip = (free_nodes > 0) ? $urandom_range(0, free_nodes - 1)
                                        : $urandom_range(0, KEY_BITS - 1);
                k = pick_stored_key() ^ (key_t'(1) << flip);
                send_item(OP_INSERT, k);
            end
            else
                send_item(OP_INSERT, key_t'($urandom()));
            rounds++;
        end
    endtask

    // Mixed traffic on the full trie: random keys, stored keys (duplicates and
    // exact matches) and near misses with random low bits flipped. Gaps are
    // switched off for some stretches.
    task automatic test_random_mix();
        int   sel;
        int   width;
        key_t k;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent % 100 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 9);
            if (sel < 4)
                k = key_t'($urandom());
            else if (sel < 7)
                k = pick_stored_key();
            else
            begin
                width = $urandom_range(1, KEY_BITS);
                k = pick_stored_key() ^ (key_t'($urandom()) & ((key_t'(1) << width) - 1'b1));
            end
            send_item($urandom_range(0, 1) ? OP_QUERY : OP_INSERT, k);
        end
        gaps_on = 1'b1;
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial
    begin
        trie_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_pool();
        test_random_mix();

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d items (%0d inserts, %0d dropped on a full pool, %0d queries).",
                 items_sent, insert_count, dropped_count, query_count);
        $display("Checked %0d results; trie ended with %0d of %0d nodes in use.",
                 results_seen, nodes_in_use, POOL_NODES);
        if (error_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding.",
                 CYCLE_LIMIT, expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
